// ===== hw/rtl/plti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_pkg
// Shared types, sizes and codes for the piecewise linear table interpolator.
// ----------------------------------------------------------------------------
package plti_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int ENTRY_W     = 3 * WORD_W;
  localparam int FRAC_BITS   = 16;
  localparam int STEP_W      = $clog2(FRAC_BITS);
  localparam int LANES       = 3;
  localparam int LANE_W      = 2;

  // command field
  localparam logic [1:0] CMD_APPEND    = 2'd1;
  localparam int         CMD_CLEAR_BIT = 1;

  // status codes
  localparam logic [2:0] ST_INTERP  = 3'd0;
  localparam logic [2:0] ST_LOW     = 3'd1;
  localparam logic [2:0] ST_HIGH    = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_LOADED  = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;
  localparam logic [2:0] ST_CLEARED = 3'd6;
  localparam logic [2:0] ST_ORDER   = 3'd7;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [WORD_W-1:0] position;
    logic signed [WORD_W-1:0] value_a;
    logic signed [WORD_W-1:0] value_b;
  } req_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [WORD_W-1:0] key_out;
    logic signed [WORD_W-1:0] result_a;
    logic signed [WORD_W-1:0] result_b;
  } rsp_t;

  typedef enum logic [2:0] {
    ADDR_MID,
    ADDR_LAST,
    ADDR_FIRST,
    ADDR_BELOW,
    ADDR_LO
  } addr_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic              load_in;
    logic              clear;
    logic              append_write;
    logic              search_init;
    logic              search_step;
    addr_sel_t         addr_sel;
    logic              set_res;
    logic              load_entry;
    logic [2:0]        res_code;
    logic              latch_lower;
    logic              div_init;
    logic              div_step;
    logic              mul_step;
    logic              add_step;
    logic [LANE_W-1:0] lane;
    logic              out_load;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cmd_clear;
    logic cmd_append;
    logic full;
    logic order_bad;
    logic count_zero;
    logic search_live;
    logic lo_past_end;
    logic lo_zero;
  } dp_sts_t;

endpackage

// ===== hw/rtl/piecewise_linear_table_interp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp
// Sample table of (key, value_a, value_b) with append, clear and interpolated
// lookup by binary search, all in signed Q16.16.
// ----------------------------------------------------------------------------
//   channel | handshake            | word
//   --------+----------------------+------------------------------------------
//   req     | req_valid/req_ready  | command, position, value_a, value_b
//   rsp     | rsp_valid/rsp_ready  | status, key_out, result_a, result_b
//
// One word at a time. Clear and append are settled in the decode state and go straight to finish.
// A query runs s = ceil(log2(count + 1)) search steps (9 for a full table):
// each search step is one RAM read plus compare, then a restoring divide
// for the 16-bit fraction and three multiply/add passes on one shared
// multiplier. Clamped and empty queries skip divide and multiply.
// req is taken while a result still waits in the output register; a stalled
// rsp holds the finished result of the next word until the register frees.
// Synchronous reset empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  plti_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output plti_pkg::rsp_t rsp
);

  plti_pkg::ctrl_cmd_t cmd;
  plti_pkg::dp_sts_t   sts;

  plti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  plti_dp u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

// ===== hw/rtl/plti_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module plti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/plti_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_ctrl
// Sequencer: decode, binary search, bracket fetch, divide, interpolate, issue.
// ----------------------------------------------------------------------------
module plti_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  plti_pkg::dp_sts_t   sts,
  output plti_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_ADDR,
    S_SRCH_CMP,
    S_EDGE,
    S_RD_LOWER,
    S_RD_UPPER,
    S_DIV,
    S_MUL,
    S_ADD,
    S_FINISH
  } state_t;

  state_t                        state, state_next;
  logic                          clamp_high, clamp_high_next;
  logic [plti_pkg::STEP_W-1:0]   step, step_next;
  logic [plti_pkg::LANE_W-1:0]   lane, lane_next;
  logic                          out_valid, out_valid_next;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = out_valid;

  always_comb begin
    cmd             = '0;
    cmd.addr_sel    = plti_pkg::ADDR_MID;
    cmd.lane        = lane;
    state_next      = state;
    clamp_high_next = clamp_high;
    step_next       = step;
    lane_next       = lane;
    case (state)
      S_IDLE: begin
        cmd.load_in = req_valid;
        if (req_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        if (sts.cmd_clear) begin
          cmd.clear    = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_code = plti_pkg::ST_CLEARED;
        end else if (sts.cmd_append) begin
          cmd.set_res = 1'b1;
          if (sts.full) begin
            cmd.res_code = plti_pkg::ST_FULL;
          end else if (sts.order_bad) begin
            cmd.res_code = plti_pkg::ST_ORDER;
          end else begin
            cmd.append_write = 1'b1;
            cmd.res_code     = plti_pkg::ST_LOADED;
          end
        end else if (sts.count_zero) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = plti_pkg::ST_EMPTY;
        end else begin
          cmd.search_init = 1'b1;
          state_next      = S_SRCH_ADDR;
        end
      end
      S_SRCH_ADDR: begin
        if (sts.search_live) begin
          cmd.addr_sel = plti_pkg::ADDR_MID;
          state_next   = S_SRCH_CMP;
        end else if (sts.lo_past_end) begin
          cmd.addr_sel    = plti_pkg::ADDR_LAST;
          clamp_high_next = 1'b1;
          state_next      = S_EDGE;
        end else if (sts.lo_zero) begin
          cmd.addr_sel    = plti_pkg::ADDR_FIRST;
          clamp_high_next = 1'b0;
          state_next      = S_EDGE;
        end else begin
          cmd.addr_sel = plti_pkg::ADDR_BELOW;
          state_next   = S_RD_LOWER;
        end
      end
      S_SRCH_CMP: begin
        cmd.search_step = 1'b1;
        state_next      = S_SRCH_ADDR;
      end
      S_EDGE: begin
        cmd.load_entry = 1'b1;
        cmd.res_code   = clamp_high ? plti_pkg::ST_HIGH : plti_pkg::ST_LOW;
        state_next     = S_FINISH;
      end
      S_RD_LOWER: begin
        cmd.latch_lower = 1'b1;
        cmd.addr_sel    = plti_pkg::ADDR_LO;
        state_next      = S_RD_UPPER;
      end
      S_RD_UPPER: begin
        cmd.div_init = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = plti_pkg::ST_INTERP;
        step_next    = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == plti_pkg::STEP_W'(plti_pkg::FRAC_BITS - 1)) begin
          lane_next  = '0;
          state_next = S_MUL;
        end else begin
          step_next = step + plti_pkg::STEP_W'(1);
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        state_next   = S_ADD;
      end
      S_ADD: begin
        cmd.add_step = 1'b1;
        if (lane == plti_pkg::LANE_W'(plti_pkg::LANES - 1)) begin
          state_next = S_FINISH;
        end else begin
          lane_next  = lane + plti_pkg::LANE_W'(1);
          state_next = S_MUL;
        end
      end
      S_FINISH: begin
        // wait for the output register to free up
        if (!out_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    out_valid_next = cmd.out_load | (out_valid & ~rsp_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      clamp_high <= 1'b0;
      step       <= '0;
      lane       <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clamp_high <= clamp_high_next;
      step       <= step_next;
      lane       <= lane_next;
      out_valid  <= out_valid_next;
    end
  end

endmodule

// ===== hw/rtl/plti_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_dp
// Datapath: table RAM, entry count, search bounds, serial divider, shared
// multiplier for interpolation, and the output register.
// ----------------------------------------------------------------------------
module plti_dp (
  input  logic                clk,
  input  logic                rst,
  input  plti_pkg::req_t      req,
  output plti_pkg::rsp_t      rsp,
  input  plti_pkg::ctrl_cmd_t cmd,
  output plti_pkg::dp_sts_t   sts
);

  localparam int W = plti_pkg::WORD_W;

  // captured request word
  logic [1:0]          cmd_reg;
  logic signed [W-1:0] x;
  logic signed [W-1:0] va;
  logic signed [W-1:0] vb;

  logic [plti_pkg::CNT_W-1:0] count;
  logic signed [W-1:0]        last_key;
  logic [plti_pkg::CNT_W-1:0] lo;
  logic [plti_pkg::CNT_W-1:0] hi;

  // bracketing entries
  logic signed [W-1:0] k0, a0, b0;
  logic signed [W-1:0] k1, a1, b1;

  logic [W-1:0]                   rem;
  logic [W-1:0]                   den;
  logic [plti_pkg::FRAC_BITS-1:0] frac;
  logic [W-1:0]                   prod_hi;
  plti_pkg::rsp_t                 work;

  logic [plti_pkg::IDX_W-1:0]   raddr;
  logic [plti_pkg::ENTRY_W-1:0] rdata;
  logic signed [W-1:0]          rd_key, rd_a, rd_b;

  logic [plti_pkg::CNT_W:0]   mid_sum;
  logic [plti_pkg::CNT_W-1:0] mid;
  logic [plti_pkg::CNT_W-1:0] count_m1;
  logic [plti_pkg::CNT_W-1:0] lo_m1;

  logic [W:0]          div_shift;
  logic [W:0]          div_sub;
  logic                div_ge;

  logic signed [W-1:0] c0, c1;
  logic signed [W:0]   diff;
  logic signed [49:0]  prod;
  logic [W-1:0]        lerp_sum;

  assign rd_key = rdata[3*W-1:2*W];
  assign rd_a   = rdata[2*W-1:W];
  assign rd_b   = rdata[W-1:0];

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[plti_pkg::CNT_W:1];
  assign count_m1 = count - plti_pkg::CNT_W'(1);
  assign lo_m1    = lo - plti_pkg::CNT_W'(1);

  always_comb begin
    case (cmd.addr_sel)
      plti_pkg::ADDR_MID:   raddr = mid[plti_pkg::IDX_W-1:0];
      plti_pkg::ADDR_LAST:  raddr = count_m1[plti_pkg::IDX_W-1:0];
      plti_pkg::ADDR_FIRST: raddr = '0;
      plti_pkg::ADDR_BELOW: raddr = lo_m1[plti_pkg::IDX_W-1:0];
      plti_pkg::ADDR_LO:    raddr = lo[plti_pkg::IDX_W-1:0];
      default:              raddr = '0;
    endcase
  end

  plti_ram #(
    .WIDTH (plti_pkg::ENTRY_W),
    .DEPTH (plti_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.append_write),
    .waddr (count[plti_pkg::IDX_W-1:0]),
    .wdata ({x, va, vb}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // one restoring step of the fraction divide
  assign div_shift = {rem, 1'b0};
  assign div_sub   = div_shift - {1'b0, den};
  assign div_ge    = (div_shift >= {1'b0, den});

  always_comb begin
    case (cmd.lane)
      2'd0:    begin c0 = k0; c1 = k1; end
      2'd1:    begin c0 = a0; c1 = a1; end
      default: begin c0 = b0; c1 = b1; end
    endcase
  end

  assign diff     = {c1[W-1], c1} - {c0[W-1], c0};
  assign prod     = diff * $signed({1'b0, frac});
  // floor of the scaled step is a plain select of the registered product
  assign lerp_sum = c0 + prod_hi;

  assign sts.cmd_clear   = cmd_reg[plti_pkg::CMD_CLEAR_BIT];
  assign sts.cmd_append  = (cmd_reg == plti_pkg::CMD_APPEND);
  assign sts.full        = (count == plti_pkg::CNT_W'(plti_pkg::TABLE_DEPTH));
  assign sts.order_bad   = (count != '0) && (x < last_key);
  assign sts.count_zero  = (count == '0);
  assign sts.search_live = (lo < hi);
  assign sts.lo_past_end = (lo >= count);
  assign sts.lo_zero     = (lo == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.append_write) begin
      count <= count + plti_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_reg <= req.command;
      x       <= req.position;
      va      <= req.value_a;
      vb      <= req.value_b;
    end
    if (cmd.append_write) begin
      last_key <= x;
    end
    if (cmd.search_init) begin
      lo <= '0;
      hi <= count;
    end else if (cmd.search_step) begin
      if (rd_key > x) begin
        hi <= mid;
      end else begin
        lo <= mid + plti_pkg::CNT_W'(1);
      end
    end
    if (cmd.latch_lower) begin
      k0 <= rd_key;
      a0 <= rd_a;
      b0 <= rd_b;
    end
    if (cmd.div_init) begin
      k1   <= rd_key;
      a1   <= rd_a;
      b1   <= rd_b;
      rem  <= x - k0;
      den  <= rd_key - k0;
      frac <= '0;
    end else if (cmd.div_step) begin
      rem  <= div_ge ? div_sub[W-1:0] : div_shift[W-1:0];
      frac <= {frac[plti_pkg::FRAC_BITS-2:0], div_ge};
    end
    if (cmd.mul_step) begin
      prod_hi <= prod[W+plti_pkg::FRAC_BITS-1:plti_pkg::FRAC_BITS];
    end
    if (cmd.set_res) begin
      work <= '{status: cmd.res_code, key_out: '0, result_a: '0, result_b: '0};
    end else if (cmd.load_entry) begin
      work.status   <= cmd.res_code;
      work.key_out  <= rd_key;
      work.result_a <= rd_a;
      work.result_b <= rd_b;
    end else if (cmd.add_step) begin
      case (cmd.lane)
        2'd0:    work.key_out  <= lerp_sum;
        2'd1:    work.result_a <= lerp_sum;
        default: work.result_b <= lerp_sum;
      endcase
    end
    if (cmd.out_load) begin
      rsp <= work;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= plti_pkg::CNT_W'(plti_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    cmd.search_step |-> (lo < hi) && (hi <= count))
    else $error("search bounds out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < den))
    else $error("divider remainder not below divisor");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    cmd.append_write |=> count == $past(count) + plti_pkg::CNT_W'(1))
    else $error("append did not advance the count");

  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> count == '0)
    else $error("clear did not empty the table");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the piecewise linear table interpolator: a directed
// run over the table's corner cases, then random clear/load/query phases with
// random idling on both channels. Every result word is checked against a
// behavioural table model kept in step with the accepted request words.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0]  CMD_QUERY    = 2'd0;
  localparam logic [1:0]  CMD_CLEAR    = 2'd2;
  localparam logic [1:0]  CMD_CLEAR_HI = 2'd3;
  localparam longint      KEY_MIN      = -64'sd2147483648;
  localparam longint      KEY_MAX      = 64'sd2147483647;
  localparam longint      Q16_ONE      = 64'sd65536;
  localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX      = 32'h7fff_ffff;
  localparam int          WORD_TARGET  = 950;
  localparam int          TAIL_CYCLES  = 100;
  localparam int          STALL_LIMIT  = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  plti_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  plti_pkg::rsp_t rsp;

  piecewise_linear_table_interp uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  // table model state
  logic signed [31:0] tab_key [plti_pkg::TABLE_DEPTH];
  logic signed [31:0] tab_va  [plti_pkg::TABLE_DEPTH];
  logic signed [31:0] tab_vb  [plti_pkg::TABLE_DEPTH];
  int                 tab_count = 0;

  plti_pkg::req_t word_q [$];
  bit             hold_q [$];
  plti_pkg::rsp_t expected_rsp_q [$];
  plti_pkg::rsp_t want;
  int     in_flight = 0;
  int     mismatches = 0;
  int     gap_left = 0;
  int     stall_left = 0;
  int     stall_draw;
  int     idle_cycles = 0;
  bit     calm_tx = 1'b0;
  bit     calm_rx = 1'b0;

  // stimulus side bookkeeping
  bit     drain_next = 1'b0;
  int     words_made = 0;
  longint gen_keys [$];

  function automatic logic signed [31:0] lerp_q16(input logic signed [31:0] c0,
                                                  input logic signed [31:0] c1,
                                                  input longint f);
    longint d;
    d = (longint'(c1) - longint'(c0)) * f;
    return 32'(longint'(c0) + (d >>> 16));
  endfunction

  function automatic plti_pkg::rsp_t table_step(input plti_pkg::req_t w);
    plti_pkg::rsp_t     r;
    logic signed [31:0] x;
    int                 idx;
    int                 sel;
    longint             num;
    longint             den;
    longint             f;
    r = '0;
    x = w.position;
    if (w.command[plti_pkg::CMD_CLEAR_BIT]) begin
      tab_count = 0;
      r.status = plti_pkg::ST_CLEARED;
    end else if (w.command == plti_pkg::CMD_APPEND) begin
      if (tab_count >= plti_pkg::TABLE_DEPTH) begin
        r.status = plti_pkg::ST_FULL;
      end else if (tab_count > 0 && x < tab_key[tab_count-1]) begin
        r.status = plti_pkg::ST_ORDER;
      end else begin
        tab_key[tab_count] = x;
        tab_va[tab_count]  = w.value_a;
        tab_vb[tab_count]  = w.value_b;
        tab_count++;
        r.status = plti_pkg::ST_LOADED;
      end
    end else if (tab_count == 0) begin
      r.status = plti_pkg::ST_EMPTY;
    end else begin
      // first entry whose key lies strictly above the position
      idx = 0;
      while (idx < tab_count && tab_key[idx] <= x) idx++;
      if (idx == tab_count || idx == 0) begin
        r.status = (idx == 0) ? plti_pkg::ST_LOW : plti_pkg::ST_HIGH;
        sel = (idx == 0) ? 0 : tab_count - 1;
        r.key_out  = tab_key[sel];
        r.result_a = tab_va[sel];
        r.result_b = tab_vb[sel];
      end else begin
        num = (longint'(x) - longint'(tab_key[idx-1])) <<< 16;
        den = longint'(tab_key[idx]) - longint'(tab_key[idx-1]);
        f = num / den;
        if (f > 65535) f = 65535;
        r.status   = plti_pkg::ST_INTERP;
        r.key_out  = lerp_q16(tab_key[idx-1], tab_key[idx], f);
        r.result_a = lerp_q16(tab_va[idx-1], tab_va[idx], f);
        r.result_b = lerp_q16(tab_vb[idx-1], tab_vb[idx], f);
      end
    end
    return r;
  endfunction

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic longint rand_between(input longint lo, input longint hi);
    longint unsigned r;
    r = {$urandom, $urandom};
    return lo + longint'(r % longint'(hi - lo + 1));
  endfunction

  task automatic push_word(input logic [1:0] cmd, input longint pos,
                           input logic [31:0] va, input logic [31:0] vb);
    plti_pkg::req_t w;
    w.command  = cmd;
    w.position = pos[31:0];
    w.value_a  = va;
    w.value_b  = vb;
    word_q.insert(word_q.size(), w);
    hold_q.insert(hold_q.size(), drain_next);
    drain_next = 1'b0;
    words_made++;
    // mirror the table's keys so that later words can be shaped
    if (cmd[plti_pkg::CMD_CLEAR_BIT]) begin
      gen_keys.delete();
    end else if (cmd == plti_pkg::CMD_APPEND && gen_keys.size() < plti_pkg::TABLE_DEPTH &&
                 (gen_keys.size() == 0 || pos >= gen_keys[$])) begin
      gen_keys.insert(gen_keys.size(), pos);
    end
  endtask

  function automatic longint pick_query();
    int     r;
    int     n;
    longint k;
    n = gen_keys.size();
    r = $urandom_range(0, 99);
    if (n == 0 || r < 15) return rand_between(KEY_MIN, KEY_MAX);
    if (r < 55) return rand_between(gen_keys[0], gen_keys[n-1]);
    if (r < 70) return gen_keys[$urandom_range(0, n-1)];
    if (r < 80) begin
      k = gen_keys[$urandom_range(0, n-1)] + ($urandom_range(0, 1) ? 1 : -1);
      return (k > KEY_MAX || k < KEY_MIN) ? gen_keys[0] : k;
    end
    if (r < 90) return rand_between(KEY_MIN, gen_keys[0]);
    return rand_between(gen_keys[n-1], KEY_MAX);
  endfunction

  task automatic query_word();
    push_word(CMD_QUERY, pick_query(), $urandom, $urandom);
  endtask

  // clear, load n ascending entries with some noise mixed in, then query
  task automatic load_phase(input int n, input int queries);
    longint k;
    longint step_max;
    int     mode;
    push_word($urandom_range(0, 1) ? CMD_CLEAR_HI : CMD_CLEAR, longint'($urandom),
              $urandom, $urandom);
    if ($urandom_range(0, 4) == 0) query_word();
    mode = $urandom_range(0, 3);
    case (mode)
      0: begin
        k = rand_between(-64'sd1048576, 64'sd1048576);
        step_max = 2;
      end
      1: begin
        k = rand_between(-64'sd16777216, 64'sd16777216);
        step_max = 64'sd262144;
      end
      2: begin
        k = rand_between(KEY_MIN, KEY_MIN + 64'sd268435456);
        step_max = 64'sd4294967296 / n;
      end
      default: begin
        k = rand_between(KEY_MIN, KEY_MAX);
        step_max = 64'sd16777216;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      if (k > KEY_MAX) k = KEY_MAX;
      push_word(plti_pkg::CMD_APPEND, k, $urandom, $urandom);
      if ($urandom_range(0, 7) == 0 && gen_keys.size() != 0 && gen_keys[$] > KEY_MIN)
        push_word(plti_pkg::CMD_APPEND, rand_between(KEY_MIN, gen_keys[$] - 1),
                  $urandom, $urandom);
      if ($urandom_range(0, 5) == 0) query_word();
      k += rand_between(0, step_max);
    end
    if (n == plti_pkg::TABLE_DEPTH) begin
      push_word(plti_pkg::CMD_APPEND, KEY_MAX, $urandom, $urandom);
      push_word(plti_pkg::CMD_APPEND, KEY_MIN, $urandom, $urandom);
    end
    for (int i = 0; i < queries; i++) query_word();
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left  <= 0;
    end else if (!req_valid || req_ready) begin
      if ($urandom_range(0, 49) == 0) calm_tx <= ~calm_tx;
      if (gap_left != 0) begin
        gap_left  <= gap_left - 1;
        req_valid <= 1'b0;
      end else if (word_q.size() != 0 && hold_q[0] && (req_valid || in_flight != 0)) begin
        // hold until every outstanding result has come back
        req_valid <= 1'b0;
      end else if (word_q.size() != 0) begin
        req       <= word_q.pop_front();
        void'(hold_q.pop_front());
        req_valid <= 1'b1;
        gap_left  <= calm_tx ? 0 : idle_length();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
    end
  endtask

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready  <= 1'b0;
      stall_left <= 0;
      in_flight  <= 0;
    end else begin
      if ($urandom_range(0, 49) == 0) calm_rx <= ~calm_rx;
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual %h", $time, rsp);
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("status", 32'(want.status), 32'(rsp.status));
          check_field("key_out", want.key_out, rsp.key_out);
          check_field("result_a", want.result_a, rsp.result_a);
          check_field("result_b", want.result_b, rsp.result_b);
        end
        stall_draw = calm_rx ? 0 : idle_length();
        stall_left <= stall_draw;
        rsp_ready  <= (stall_draw == 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        rsp_ready  <= (stall_left == 1);
      end else begin
        rsp_ready <= calm_rx || ($urandom_range(0, 9) != 0);
      end
      if (req_valid && req_ready)
        expected_rsp_q.insert(expected_rsp_q.size(), table_step(req));
      in_flight <= expected_rsp_q.size();
    end
  end

  // watchdog: count cycles in which neither channel moves a word
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // empty table, single entry, equal keys, ordering, extremes
    push_word(CMD_QUERY, 0, $urandom, $urandom);
    push_word(CMD_CLEAR, KEY_MAX, VAL_MAX, VAL_MAX);
    push_word(CMD_QUERY, KEY_MAX, $urandom, $urandom);
    push_word(plti_pkg::CMD_APPEND, Q16_ONE, VAL_MIN, VAL_MAX);
    push_word(CMD_QUERY, KEY_MIN, $urandom, $urandom);
    push_word(CMD_QUERY, Q16_ONE, $urandom, $urandom);
    push_word(CMD_QUERY, Q16_ONE - 1, $urandom, $urandom);
    push_word(plti_pkg::CMD_APPEND, Q16_ONE, 32'h0000_0005, 32'hffff_fffb);
    push_word(plti_pkg::CMD_APPEND, 0, $urandom, $urandom);
    push_word(plti_pkg::CMD_APPEND, KEY_MAX, VAL_MAX, VAL_MIN);
    push_word(CMD_QUERY, Q16_ONE, $urandom, $urandom);
    push_word(CMD_QUERY, 64'sh4000_0000, $urandom, $urandom);
    push_word(CMD_QUERY, KEY_MAX - 1, $urandom, $urandom);
    push_word(CMD_QUERY, KEY_MAX, $urandom, $urandom);
    push_word(plti_pkg::CMD_APPEND, KEY_MIN, VAL_MIN, VAL_MIN);
    push_word(CMD_CLEAR_HI, KEY_MIN, VAL_MAX, VAL_MIN);
    push_word(CMD_QUERY, KEY_MIN, $urandom, $urandom);
    push_word(plti_pkg::CMD_APPEND, KEY_MIN, VAL_MAX, VAL_MIN);
    push_word(plti_pkg::CMD_APPEND, KEY_MAX, VAL_MIN, VAL_MAX);
    push_word(CMD_QUERY, KEY_MIN, $urandom, $urandom);
    push_word(CMD_QUERY, 0, $urandom, $urandom);
    push_word(CMD_QUERY, -1, $urandom, $urandom);
    push_word(CMD_QUERY, KEY_MAX - 1, $urandom, $urandom);
    push_word(CMD_QUERY, KEY_MAX, $urandom, $urandom);

    // random phases; the third one fills the table to the top
    for (int phase = 0; words_made < WORD_TARGET; phase++) begin
      drain_next = (phase == 0) || ($urandom_range(0, 3) == 0);
      if (phase == 2) load_phase(plti_pkg::TABLE_DEPTH, 30);
      else if ($urandom_range(0, 3) == 0)
        load_phase($urandom_range(9, 40), $urandom_range(8, 30));
      else
        load_phase($urandom_range(1, 8), $urandom_range(3, 15));
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (word_q.size() != 0 || req_valid || expected_rsp_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
